// ----- rtl/core/atb_pkg.sv -----
package atb_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int FRAC_BITS   = 16;
    localparam int W_W         = 16;
    localparam int SUM_W       = 22;
    localparam int PROB_W      = 17;
    localparam int PROD_W      = W_W + CNT_W;
    localparam int SCL_W       = CNT_W + FRAC_BITS;
    localparam int DVD_W       = PROD_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(SCL_W + 1);

    localparam logic [SCL_W-1:0] ONE_FX = SCL_W'(1) << FRAC_BITS;

endpackage

// ----- rtl/core/atb_divider.sv -----
module atb_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [atb_pkg::DVD_W-1:0]    i_dividend,
    input  logic [atb_pkg::SUM_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [atb_pkg::SCL_W-1:0]    o_quot
);
    import atb_pkg::*;

    logic [SUM_W-1:0]     r_rem;
    logic [SCL_W-1:0]     r_q;
    logic [SUM_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;
    logic [SUM_W:0]       trial;
    logic [SUM_W:0]       diff;
    logic                 ge;

    // restoring division, one quotient bit per cycle; quotient fits SCL_W bits
    assign trial = {r_rem, r_q[SCL_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_CNT_W'(SCL_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SUM_W'(i_dividend[DVD_W-1:SCL_W]);
            r_q   <= i_dividend[SCL_W-1:0];
            r_div <= i_divisor;
        end else if (r_run) begin
            r_rem <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            r_q   <= {r_q[SCL_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/core/alias_table_builder_core.sv -----
// Vose alias table builder. Weights are loaded one per transaction (start high
// while busy is low); a transaction with i_last set, or the 64th one, closes
// the set. busy then rises for the build: each entry is scaled by a
// bit-serial divider, small/large entries are paired, leftover entries are
// written, then the table streams out one entry per cycle in index order,
// o_valid marking each result for exactly one cycle. The receiver cannot
// stall the stream and must take every result as it appears. A set holding a
// negative weight gives a single result with o_error and o_end_of_table set,
// in the cycle after the closing transaction. Per-entry data lives in
// single-write-port memories (weights, scaled values, two stacks, table) with
// registered reads.
module alias_table_builder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [atb_pkg::W_W-1:0] i_weight,
    input  logic                          i_last,
    output logic                          o_valid,
    output logic [atb_pkg::IDX_W-1:0]     o_index,
    output logic [atb_pkg::PROB_W-1:0]    o_prob,
    output logic [atb_pkg::IDX_W-1:0]     o_alias_res,
    output logic                          o_error,
    output logic                          o_end_of_table
);
    import atb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SC_RD, S_SC_MUL, S_SC_DIV, S_SC_WR,
        S_PR_RD, S_PR_VAL, S_PR_WR, S_LO_RD, S_LO_WR, S_EMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt, r_n, r_i, r_sc, r_lc;
    logic [SUM_W-1:0] r_sum;
    logic             r_neg;
    logic [SCL_W-1:0] r_scl;

    // memories
    logic [W_W-1:0]    mem_w   [MAX_ENTRIES];
    logic [SCL_W-1:0]  mem_scl [MAX_ENTRIES];
    logic [IDX_W-1:0]  mem_sm  [MAX_ENTRIES];
    logic [IDX_W-1:0]  mem_lg  [MAX_ENTRIES];
    logic [PROB_W-1:0] mem_ep  [MAX_ENTRIES];
    logic [IDX_W-1:0]  mem_ea  [MAX_ENTRIES];

    logic [W_W-1:0]    r_w_rd;
    logic [SCL_W-1:0]  r_sp_s, r_sp_l;
    logic [IDX_W-1:0]  r_sm_rd, r_lg_rd;
    logic [PROB_W-1:0] r_ep_rd;
    logic [IDX_W-1:0]  r_ea_rd;

    // emit pipeline
    logic             r_rd_v, r_rd_eot;
    logic [IDX_W-1:0] r_rd_idx;

    // write ports
    logic              scl_we, sm_we, lg_we, ent_we;
    logic [IDX_W-1:0]  scl_wa, sm_wa, lg_wa, ent_wa, ent_wal;
    logic [SCL_W-1:0]  scl_wd;
    logic [IDX_W-1:0]  sm_wd, lg_wd;
    logic [PROB_W-1:0] ent_wp;

    logic             acc, close, neg_in;
    logic [SCL_W-1:0] pair_val;
    logic [PROD_W-1:0] prod;
    logic             div_start, div_done;
    logic [SCL_W-1:0] div_quot;

    assign acc      = start && !busy;
    assign neg_in   = i_weight[W_W-1];
    assign close    = i_last || (r_cnt == CNT_W'(MAX_ENTRIES - 1));
    assign busy     = (r_state != S_IDLE) || r_rd_v;
    assign pair_val = SCL_W'({1'b0, r_sp_l} + {1'b0, r_sp_s} - {1'b0, ONE_FX});
    assign prod     = PROD_W'(r_w_rd) * PROD_W'(r_n);
    assign div_start = (r_state == S_SC_MUL) && (r_sum != '0);

    atb_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({prod, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // memory write steering
    always_comb begin
        scl_we  = 1'b0;
        scl_wa  = r_i[IDX_W-1:0];
        scl_wd  = r_scl;
        sm_we   = 1'b0;
        sm_wa   = r_sc[IDX_W-1:0];
        sm_wd   = r_i[IDX_W-1:0];
        lg_we   = 1'b0;
        lg_wa   = r_lc[IDX_W-1:0];
        lg_wd   = r_i[IDX_W-1:0];
        ent_we  = 1'b0;
        ent_wa  = r_sm_rd;
        ent_wp  = PROB_W'(ONE_FX);
        ent_wal = r_lg_rd;
        unique case (r_state)
            S_SC_WR: begin
                scl_we = 1'b1;
                sm_we  = (r_scl < ONE_FX);
                lg_we  = !(r_scl < ONE_FX);
            end
            S_PR_WR: begin
                scl_we  = 1'b1;
                scl_wa  = r_lg_rd;
                scl_wd  = pair_val;
                ent_we  = 1'b1;
                ent_wp  = PROB_W'(r_sp_s);
                // l goes back on top of the stack it belongs to
                sm_we   = (pair_val < ONE_FX);
                lg_we   = !(pair_val < ONE_FX);
                sm_wa   = IDX_W'(r_sc - 1'b1);
                lg_wa   = IDX_W'(r_lc - 1'b1);
                sm_wd   = r_lg_rd;
                lg_wd   = r_lg_rd;
            end
            S_LO_WR: begin
                ent_we  = 1'b1;
                ent_wa  = (r_lc != '0) ? r_lg_rd : r_sm_rd;
                ent_wal = (r_lc != '0) ? r_lg_rd : r_sm_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc) mem_w[r_cnt[IDX_W-1:0]] <= i_weight;
        r_w_rd <= mem_w[r_i[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (scl_we) mem_scl[scl_wa] <= scl_wd;
        r_sp_s <= mem_scl[r_sm_rd];
        r_sp_l <= mem_scl[r_lg_rd];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) mem_sm[sm_wa] <= sm_wd;
        r_sm_rd <= mem_sm[IDX_W'(r_sc - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (lg_we) mem_lg[lg_wa] <= lg_wd;
        r_lg_rd <= mem_lg[IDX_W'(r_lc - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_ep[ent_wa] <= ent_wp;
            mem_ea[ent_wa] <= ent_wal;
        end
        r_ep_rd <= mem_ep[r_i[IDX_W-1:0]];
        r_ea_rd <= mem_ea[r_i[IDX_W-1:0]];
    end

    // next state after the stack counts settle
    function automatic t_state after_stacks(input logic [CNT_W-1:0] sc,
                                            input logic [CNT_W-1:0] lc);
        t_state nxt;
        if (sc != '0 && lc != '0)      nxt = S_PR_RD;
        else if (sc != '0 || lc != '0) nxt = S_LO_RD;
        else                           nxt = S_EMIT;
        return nxt;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_neg    <= 1'b0;
            r_sc     <= '0;
            r_lc     <= '0;
            r_i      <= '0;
            r_n      <= '0;
            r_rd_v   <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_rd_v   <= 1'b0;
            r_rd_idx <= r_i[IDX_W-1:0];
            r_rd_eot <= (r_i == r_n - 1'b1);
            // results leave in the cycle after the table read
            o_valid        <= r_rd_v;
            o_index        <= r_rd_idx;
            o_prob         <= r_ep_rd;
            o_alias_res    <= r_ea_rd;
            o_error        <= 1'b0;
            o_end_of_table <= r_rd_eot;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (neg_in) r_neg <= 1'b1;
                        else        r_sum <= r_sum + SUM_W'(unsigned'(i_weight));
                        if (close) begin
                            r_cnt <= '0;
                            r_neg <= 1'b0;
                            if (r_neg || neg_in) begin
                                r_sum          <= '0;
                                o_valid        <= 1'b1;
                                o_index        <= '0;
                                o_prob         <= '0;
                                o_alias_res    <= '0;
                                o_error        <= 1'b1;
                                o_end_of_table <= 1'b1;
                            end else begin
                                r_n     <= r_cnt + 1'b1;
                                r_i     <= '0;
                                r_sc    <= '0;
                                r_lc    <= '0;
                                r_state <= S_SC_RD;
                            end
                        end
                    end
                end
                S_SC_RD:  r_state <= S_SC_MUL;
                S_SC_MUL: begin
                    if (r_sum == '0) begin
                        r_scl   <= ONE_FX;
                        r_state <= S_SC_WR;
                    end else begin
                        r_state <= S_SC_DIV;
                    end
                end
                S_SC_DIV: begin
                    if (div_done) begin
                        r_scl   <= div_quot;
                        r_state <= S_SC_WR;
                    end
                end
                S_SC_WR: begin
                    if (r_scl < ONE_FX) r_sc <= r_sc + 1'b1;
                    else                r_lc <= r_lc + 1'b1;
                    r_i <= r_i + 1'b1;
                    if (r_i == r_n - 1'b1) begin
                        r_i     <= '0;
                        r_state <= (r_scl < ONE_FX) ? after_stacks(r_sc + 1'b1, r_lc)
                                                    : after_stacks(r_sc, r_lc + 1'b1);
                    end else begin
                        r_state <= S_SC_RD;
                    end
                end
                S_PR_RD:  r_state <= S_PR_VAL;
                S_PR_VAL: r_state <= S_PR_WR;
                S_PR_WR: begin
                    if (pair_val < ONE_FX) begin
                        r_lc    <= r_lc - 1'b1;
                        r_state <= after_stacks(r_sc, r_lc - 1'b1);
                    end else begin
                        r_sc    <= r_sc - 1'b1;
                        r_state <= after_stacks(r_sc - 1'b1, r_lc);
                    end
                end
                S_LO_RD:  r_state <= S_LO_WR;
                S_LO_WR: begin
                    if (r_lc != '0) begin
                        r_lc    <= r_lc - 1'b1;
                        r_state <= after_stacks(r_sc, r_lc - 1'b1);
                    end else begin
                        r_sc    <= r_sc - 1'b1;
                        r_state <= after_stacks(r_sc - 1'b1, r_lc);
                    end
                end
                S_EMIT: begin
                    r_rd_v <= 1'b1;
                    r_i    <= r_i + 1'b1;
                    if (r_i == r_n - 1'b1) begin
                        r_sum   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/atb_checker.sv -----
module atb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       busy,
    input logic                       o_valid,
    input logic [atb_pkg::IDX_W-1:0]  o_index,
    input logic [atb_pkg::PROB_W-1:0] o_prob,
    input logic                       o_error,
    input logic                       o_end_of_table
);
    import atb_pkg::*;

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_end_of_table && o_index == '0 && o_prob == '0)
        else $error("error result malformed");

    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error |-> o_prob <= PROB_W'(ONE_FX))
        else $error("probability above one");

    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_table |=> o_valid && o_index == IDX_W'($past(o_index) + 1'b1))
        else $error("table stream broken");

    // only an error result can follow the end of a build straight away
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_table |=> !o_valid || o_error)
        else $error("table entry right after end of table");

    a_busy_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_table |-> busy)
        else $error("idle during table stream");

endmodule

bind alias_table_builder_core atb_checker u_atb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_index        (o_index),
    .o_prob         (o_prob),
    .o_error        (o_error),
    .o_end_of_table (o_end_of_table)
);
